// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker module of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that is checked at every clock edge, reset included.
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tcpct_pkg.sv =====
// Types, constants and helpers of the TCP connection table.
// No dependencies; used by every module of the block.
`default_nettype none
package tcpct_pkg;

  localparam int NUM_SLOTS_DEF   = 8;
  localparam int MAX_PAYLOAD_DEF = 1460;
  localparam logic [31:0] INITIAL_SEQ = 32'd1000;

  localparam logic [2:0] ST_CLOSED     = 3'd0;
  localparam logic [2:0] ST_LISTEN     = 3'd1;
  localparam logic [2:0] ST_SYN_SENT   = 3'd2;
  localparam logic [2:0] ST_SYN_RCVD   = 3'd3;
  localparam logic [2:0] ST_ESTAB      = 3'd4;
  localparam logic [2:0] ST_CLOSE_WAIT = 3'd5;

  localparam logic [5:0] FL_FIN = 6'd1;
  localparam logic [5:0] FL_SYN = 6'd2;
  localparam logic [5:0] FL_RST = 6'd4;
  localparam logic [5:0] FL_PSH = 6'd8;
  localparam logic [5:0] FL_ACK = 6'd16;

  localparam logic [2:0] MODE_RECV    = 3'd0;
  localparam logic [2:0] MODE_LISTEN  = 3'd1;
  localparam logic [2:0] MODE_CONNECT = 3'd2;
  localparam logic [2:0] MODE_SEND    = 3'd3;
  localparam logic [2:0] MODE_CLOSE   = 3'd4;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_CONNECTED = 2'd1;
  localparam logic [1:0] EV_DATA      = 2'd2;
  localparam logic [1:0] EV_CLOSED    = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  typedef enum logic [2:0] {
    OP_RECV, OP_LISTEN, OP_CONNECT, OP_SEND, OP_CLOSE, OP_BAD
  } op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  slot;
    logic [31:0] local_addr;
    logic [15:0] local_port_in;
    logic [31:0] remote_addr;
    logic [15:0] remote_port_in;
    logic [31:0] seq_in;
    logic [5:0]  flags_in;
    logic [10:0] length;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [31:0] tx_dest_addr;
    logic [15:0] tx_src_port;
    logic [15:0] tx_dest_port;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [5:0]  tx_flags;
    logic [2:0]  slot_out;
    logic [1:0]  event_res;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    op_t   op;
    item_t item;
  } qent_t;

  // Header fields are forced to zero when no segment is sent.
  function automatic res_t mk_res(input logic tx, input logic [31:0] addr,
                                  input logic [15:0] sport, input logic [15:0] dport,
                                  input logic [31:0] seq, input logic [31:0] ack,
                                  input logic [5:0] flags, input logic [2:0] slot,
                                  input logic [1:0] ev, input logic [1:0] st,
                                  input logic last);
    res_t r;
    r.tx_valid     = tx;
    r.tx_dest_addr = tx ? addr : 32'd0;
    r.tx_src_port  = tx ? sport : 16'd0;
    r.tx_dest_port = tx ? dport : 16'd0;
    r.tx_seq       = tx ? seq : 32'd0;
    r.tx_ack       = tx ? ack : 32'd0;
    r.tx_flags     = tx ? flags : 6'd0;
    r.slot_out     = slot;
    r.event_res    = ev;
    r.status       = st;
    r.last         = last;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tcpct_front.sv =====
// Front end: accepts input transactions, classifies the mode and queues them.
// Depends on tcpct_pkg.
`default_nettype none
module tcpct_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tcpct_pkg::item_t in_data,
  output logic                  q_valid,
  output tcpct_pkg::qent_t      q_data,
  input  wire logic             q_pop
);

  tcpct_pkg::qent_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  tcpct_pkg::op_t op;

  always_comb begin
    unique case (in_data.mode)
      tcpct_pkg::MODE_RECV:    op = tcpct_pkg::OP_RECV;
      tcpct_pkg::MODE_LISTEN:  op = tcpct_pkg::OP_LISTEN;
      tcpct_pkg::MODE_CONNECT: op = tcpct_pkg::OP_CONNECT;
      tcpct_pkg::MODE_SEND:    op = tcpct_pkg::OP_SEND;
      tcpct_pkg::MODE_CLOSE:   op = tcpct_pkg::OP_CLOSE;
      default:                 op = tcpct_pkg::OP_BAD;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ (q_pop && q_valid);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{op: op, item: in_data};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcpct_back.sv =====
// Back end: connection table, sequential tuple match and per-entry state machine.
// Depends on tcpct_pkg.
`default_nettype none
module tcpct_back #(
  parameter int NUM_SLOTS   = tcpct_pkg::NUM_SLOTS_DEF,
  parameter int MAX_PAYLOAD = tcpct_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire tcpct_pkg::qent_t  q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tcpct_pkg::res_t        out_data
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int UW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_SCAN, S_LSCAN, S_EXEC, S_OUT1, S_OUT2
  } state_t;

  state_t st_r;
  tcpct_pkg::qent_t cur_r;
  logic [IW-1:0] idx_r;
  logic [UW-1:0] used_r;
  logic [31:0]   cnt_r;
  tcpct_pkg::res_t res1_r, res2_r, out_r;
  logic          two_r, ov_r;

  logic          act_r [NUM_SLOTS];
  logic [2:0]    est_r [NUM_SLOTS];
  logic [31:0]   la_r  [NUM_SLOTS];
  logic [15:0]   lp_r  [NUM_SLOTS];
  logic [31:0]   ra_r  [NUM_SLOTS];
  logic [15:0]   rp_r  [NUM_SLOTS];
  logic [31:0]   ss_r  [NUM_SLOTS];
  logic [31:0]   ack_r [NUM_SLOTS];

  tcpct_pkg::item_t it;
  tcpct_pkg::res_t  exec_res, fin_res;
  logic [IW-1:0] aidx;
  logic [31:0]   cnt_inc, seq1, seqlen;
  logic [15:0]   eph;
  logic [2:0]    sl3;
  logic          full, slot_ok, tup_hit, lst_hit, scan_end, syn_only, out_free;
  logic          f_syn, f_ack, f_psh, f_fin, send_ok, out_load;

  assign it       = cur_r.item;
  assign aidx     = IW'(used_r);
  assign full     = (used_r == UW'(NUM_SLOTS));
  assign cnt_inc  = cnt_r + 32'd1;
  // Ephemeral port: 32768 plus the advanced counter modulo 32768.
  assign eph      = {1'b1, cnt_inc[14:0]};
  assign seq1     = it.seq_in + 32'd1;
  assign seqlen   = it.seq_in + 32'(it.length);
  assign sl3      = 3'(idx_r);
  assign slot_ok  = {4'd0, it.slot} < 7'(NUM_SLOTS);
  assign f_syn    = (it.flags_in & tcpct_pkg::FL_SYN) != 6'd0;
  assign f_ack    = (it.flags_in & tcpct_pkg::FL_ACK) != 6'd0;
  assign f_psh    = (it.flags_in & tcpct_pkg::FL_PSH) != 6'd0;
  assign f_fin    = (it.flags_in & tcpct_pkg::FL_FIN) != 6'd0;
  assign syn_only = f_syn && !f_ack;
  assign scan_end = (idx_r == IW'(NUM_SLOTS - 1));
  assign tup_hit  = act_r[idx_r] && la_r[idx_r] == it.local_addr
                    && lp_r[idx_r] == it.local_port_in && ra_r[idx_r] == it.remote_addr
                    && rp_r[idx_r] == it.remote_port_in;
  assign lst_hit  = act_r[idx_r] && la_r[idx_r] == it.local_addr
                    && lp_r[idx_r] == it.local_port_in && est_r[idx_r] == tcpct_pkg::ST_LISTEN;
  assign send_ok  = est_r[idx_r] == tcpct_pkg::ST_ESTAB && it.length != 11'd0
                    && {5'd0, it.length} <= 16'(MAX_PAYLOAD);
  assign out_free = !ov_r || !out_stall;
  assign out_load = (st_r == S_OUT1 || st_r == S_OUT2) && out_free;
  assign q_pop    = (st_r == S_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Result of the execute step for the entry selected by idx_r.
  always_comb begin
    fin_res = tcpct_pkg::mk_res(1'b1, it.remote_addr, it.local_port_in,
      it.remote_port_in, ss_r[idx_r], seq1, tcpct_pkg::FL_ACK, sl3,
      tcpct_pkg::EV_CLOSED, tcpct_pkg::STAT_OK, 1'b1);
    exec_res = tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, sl3,
      tcpct_pkg::EV_NONE, tcpct_pkg::STAT_OK, 1'b1);
    case (cur_r.op)
      tcpct_pkg::OP_SEND: begin
        if (send_ok) begin
          exec_res = tcpct_pkg::mk_res(1'b1, ra_r[idx_r], lp_r[idx_r], rp_r[idx_r],
            ss_r[idx_r], ack_r[idx_r], tcpct_pkg::FL_PSH | tcpct_pkg::FL_ACK, sl3,
            tcpct_pkg::EV_NONE, tcpct_pkg::STAT_OK, 1'b1);
        end else begin
          exec_res = tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, sl3,
            tcpct_pkg::EV_NONE, tcpct_pkg::STAT_INVALID, 1'b1);
        end
      end
      tcpct_pkg::OP_CLOSE: begin
        if (est_r[idx_r] == tcpct_pkg::ST_CLOSED) begin
          exec_res = tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, sl3,
            tcpct_pkg::EV_NONE, tcpct_pkg::STAT_INVALID, 1'b1);
        end else if (est_r[idx_r] == tcpct_pkg::ST_ESTAB) begin
          exec_res = tcpct_pkg::mk_res(1'b1, ra_r[idx_r], lp_r[idx_r], rp_r[idx_r],
            ss_r[idx_r], ack_r[idx_r], tcpct_pkg::FL_FIN | tcpct_pkg::FL_ACK, sl3,
            tcpct_pkg::EV_NONE, tcpct_pkg::STAT_OK, 1'b1);
        end
      end
      default: begin
        case (est_r[idx_r])
          tcpct_pkg::ST_LISTEN: begin
            if (f_syn) begin
              exec_res = tcpct_pkg::mk_res(1'b1, it.remote_addr, it.local_port_in,
                it.remote_port_in, cnt_r, seq1, tcpct_pkg::FL_SYN | tcpct_pkg::FL_ACK,
                sl3, tcpct_pkg::EV_NONE, tcpct_pkg::STAT_OK, 1'b1);
            end
          end
          tcpct_pkg::ST_SYN_SENT: begin
            if (f_syn && f_ack) begin
              exec_res = tcpct_pkg::mk_res(1'b1, it.remote_addr, it.local_port_in,
                it.remote_port_in, ss_r[idx_r] + 32'd1, seq1, tcpct_pkg::FL_ACK,
                sl3, tcpct_pkg::EV_CONNECTED, tcpct_pkg::STAT_OK, 1'b1);
            end
          end
          tcpct_pkg::ST_SYN_RCVD: begin
            if (f_ack) begin
              exec_res = tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, sl3,
                tcpct_pkg::EV_CONNECTED, tcpct_pkg::STAT_OK, 1'b1);
            end
          end
          tcpct_pkg::ST_ESTAB: begin
            if (f_psh) begin
              exec_res = tcpct_pkg::mk_res(1'b1, it.remote_addr, it.local_port_in,
                it.remote_port_in, ss_r[idx_r], seqlen, tcpct_pkg::FL_ACK, sl3,
                (it.length != 11'd0) ? tcpct_pkg::EV_DATA : tcpct_pkg::EV_NONE,
                tcpct_pkg::STAT_OK, !f_fin);
            end else if (f_fin) begin
              exec_res = fin_res;
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      used_r <= '0;
      cnt_r  <= tcpct_pkg::INITIAL_SEQ;
      ov_r   <= 1'b0;
      two_r  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        act_r[i] <= 1'b0;
        est_r[i] <= tcpct_pkg::ST_CLOSED;
      end
    end else begin
      ov_r <= out_load || (ov_r && out_stall);
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_data;
            two_r <= 1'b0;
            st_r  <= S_DEC;
          end
        end
        S_DEC: begin
          unique case (cur_r.op)
            tcpct_pkg::OP_RECV: begin
              idx_r <= '0;
              st_r  <= S_SCAN;
            end
            tcpct_pkg::OP_LISTEN: begin
              st_r <= S_OUT1;
              if (full) begin
                res1_r <= tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, 3'd0,
                  tcpct_pkg::EV_NONE, tcpct_pkg::STAT_FULL, 1'b1);
              end else begin
                act_r[aidx] <= 1'b1;
                est_r[aidx] <= tcpct_pkg::ST_LISTEN;
                la_r[aidx]  <= it.local_addr;
                lp_r[aidx]  <= it.local_port_in;
                ra_r[aidx]  <= '0;
                rp_r[aidx]  <= '0;
                ss_r[aidx]  <= cnt_r;
                ack_r[aidx] <= '0;
                cnt_r       <= cnt_inc;
                used_r      <= used_r + UW'(1);
                res1_r <= tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, 3'(aidx),
                  tcpct_pkg::EV_NONE, tcpct_pkg::STAT_OK, 1'b1);
              end
            end
            tcpct_pkg::OP_CONNECT: begin
              st_r <= S_OUT1;
              if (it.remote_addr == 32'd0 || it.remote_port_in == 16'd0) begin
                res1_r <= tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, 3'd0,
                  tcpct_pkg::EV_NONE, tcpct_pkg::STAT_INVALID, 1'b1);
              end else if (full) begin
                res1_r <= tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, 3'd0,
                  tcpct_pkg::EV_NONE, tcpct_pkg::STAT_FULL, 1'b1);
              end else begin
                act_r[aidx] <= 1'b1;
                est_r[aidx] <= tcpct_pkg::ST_SYN_SENT;
                la_r[aidx]  <= it.local_addr;
                lp_r[aidx]  <= eph;
                ra_r[aidx]  <= it.remote_addr;
                rp_r[aidx]  <= it.remote_port_in;
                ss_r[aidx]  <= cnt_r;
                ack_r[aidx] <= '0;
                cnt_r       <= cnt_inc;
                used_r      <= used_r + UW'(1);
                res1_r <= tcpct_pkg::mk_res(1'b1, it.remote_addr, eph, it.remote_port_in,
                  cnt_r, 32'd0, tcpct_pkg::FL_SYN, 3'(aidx), tcpct_pkg::EV_NONE,
                  tcpct_pkg::STAT_OK, 1'b1);
              end
            end
            tcpct_pkg::OP_SEND, tcpct_pkg::OP_CLOSE: begin
              if (slot_ok) begin
                idx_r <= IW'(it.slot);
                st_r  <= S_EXEC;
              end else begin
                st_r   <= S_OUT1;
                res1_r <= tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, it.slot,
                  tcpct_pkg::EV_NONE, tcpct_pkg::STAT_INVALID, 1'b1);
              end
            end
            default: begin
              st_r   <= S_OUT1;
              res1_r <= tcpct_pkg::mk_res(1'b0, '0, '0, '0, '0, '0, '0, 3'd0,
                tcpct_pkg::EV_NONE, tcpct_pkg::STAT_INVALID, 1'b1);
            end
          endcase
        end
        S_SCAN, S_LSCAN: begin
          if (st_r == S_SCAN ? tup_hit : lst_hit) begin
            if (st_r == S_LSCAN) begin
              // A listener that takes the SYN adopts the sender as its peer.
              ra_r[idx_r] <= it.remote_addr;
              rp_r[idx_r] <= it.remote_port_in;
            end
            st_r <= S_EXEC;
          end else if (!scan_end) begin
            idx_r <= idx_r + IW'(1);
          end else if (st_r == S_SCAN && syn_only) begin
            idx_r <= '0;
            st_r  <= S_LSCAN;
          end else begin
            res1_r <= tcpct_pkg::mk_res(1'b1, it.remote_addr, it.local_port_in,
              it.remote_port_in, 32'd0, seq1, tcpct_pkg::FL_RST | tcpct_pkg::FL_ACK,
              3'd0, tcpct_pkg::EV_NONE, tcpct_pkg::STAT_OK, 1'b1);
            st_r <= S_OUT1;
          end
        end
        S_EXEC: begin
          st_r   <= S_OUT1;
          res1_r <= exec_res;
          case (cur_r.op)
            tcpct_pkg::OP_SEND: begin
              if (send_ok) begin
                ss_r[idx_r] <= ss_r[idx_r] + 32'(it.length);
              end
            end
            tcpct_pkg::OP_CLOSE: begin
              if (est_r[idx_r] != tcpct_pkg::ST_CLOSED) begin
                act_r[idx_r] <= 1'b0;
                est_r[idx_r] <= tcpct_pkg::ST_CLOSED;
              end
            end
            default: begin
              case (est_r[idx_r])
                tcpct_pkg::ST_LISTEN: begin
                  if (f_syn) begin
                    ack_r[idx_r] <= seq1;
                    ss_r[idx_r]  <= cnt_r;
                    cnt_r        <= cnt_inc;
                    est_r[idx_r] <= tcpct_pkg::ST_SYN_RCVD;
                  end
                end
                tcpct_pkg::ST_SYN_SENT: begin
                  if (f_syn && f_ack) begin
                    ack_r[idx_r] <= seq1;
                    est_r[idx_r] <= tcpct_pkg::ST_ESTAB;
                  end
                end
                tcpct_pkg::ST_SYN_RCVD: begin
                  if (f_ack) begin
                    est_r[idx_r] <= tcpct_pkg::ST_ESTAB;
                  end
                end
                tcpct_pkg::ST_ESTAB: begin
                  if (f_fin) begin
                    est_r[idx_r] <= tcpct_pkg::ST_CLOSE_WAIT;
                    ack_r[idx_r] <= seq1;
                    if (f_psh) begin
                      two_r  <= 1'b1;
                      res2_r <= fin_res;
                    end
                  end else if (f_psh) begin
                    ack_r[idx_r] <= seqlen;
                  end
                end
                default: begin
                end
              endcase
            end
          endcase
        end
        S_OUT1: begin
          if (out_free) begin
            out_r <= res1_r;
            st_r  <= two_r ? S_OUT2 : S_IDLE;
          end
        end
        S_OUT2: begin
          if (out_free) begin
            out_r <= res2_r;
            st_r  <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcp_connection_table_fsm.sv =====
// Top level of the TCP connection table: front queue plus table back end.
// Depends on tcpct_pkg, tcpct_front and tcpct_back.
//
//   channel | direction | payload            | handshake
//   in      | input     | tcpct_pkg::item_t  | in_valid / in_stall
//   out     | output    | tcpct_pkg::res_t   | out_valid / out_stall
//
// Listen, connect and undefined modes go from decode to output; send and close with a
// valid slot pass an execute step first. A received segment scans the table one entry
// per cycle: up to every entry for the tuple match, then, for a SYN without ACK that
// found none, up to every entry for the listener match. The front queue holds two
// items, so the input takes up to two while the back end works or its result waits
// under out_stall. Synchronous reset clears entry states and slot count, presets the sequence counter.
`default_nettype none
module tcp_connection_table_fsm #(
  parameter int NUM_SLOTS   = tcpct_pkg::NUM_SLOTS_DEF,
  parameter int MAX_PAYLOAD = tcpct_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tcpct_pkg::item_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output tcpct_pkg::res_t       out_data
);

  logic             q_valid, q_pop;
  tcpct_pkg::qent_t q_data;

  tcpct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  tcpct_back #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/tcpct_checker.sv =====
// Port-level checks of the TCP connection table, bound to the top level.
// Depends on tcpct_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tcpct_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire tcpct_pkg::res_t  out_data
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "output changed while stalled")
  `ASSERT_CLK_ALL(a_reset_quiet, clk, !rst_n |=> !out_valid, "output valid right after reset")
  `ASSERT_CLK(a_no_tx_zero, clk, rst_n, out_valid && !out_data.tx_valid |-> out_data.tx_flags == 6'd0 && out_data.tx_dest_addr == 32'd0 && out_data.tx_seq == 32'd0, "header set without transmit")
  `ASSERT_CLK(a_event_ok, clk, rst_n, out_valid && out_data.event_res != tcpct_pkg::EV_NONE |-> out_data.status == tcpct_pkg::STAT_OK, "event with error status")

endmodule

bind tcp_connection_table_fsm tcpct_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== dv/tb_tcp_connection_table_fsm.sv =====
// Self-checking testbench for the TCP connection table: directed connection
// sequences, then random traffic, predicted by an in-bench table model.
// Depends on tcpct_pkg and the RTL top tcp_connection_table_fsm.
`default_nettype none
module tb_tcp_connection_table_fsm;
  timeunit 1ns;
  timeprecision 1ps;
  import tcpct_pkg::*;

  localparam int SLOTS = 8;
  localparam int PAYLOAD_MAX = 1460;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;

  tcp_connection_table_fsm i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: a copy of the connection table.
  logic        tbl_active[SLOTS];
  logic [2:0]  tbl_state[SLOTS];
  logic [31:0] tbl_laddr[SLOTS];
  logic [15:0] tbl_lport[SLOTS];
  logic [31:0] tbl_raddr[SLOTS];
  logic [15:0] tbl_rport[SLOTS];
  logic [31:0] tbl_snd[SLOTS];
  logic [31:0] tbl_ack[SLOTS];
  int          tbl_used;
  logic [31:0] isn_counter;

  item_t pending_items[$];
  res_t  expected_results[$];
  int    mismatches = 0;

  function automatic res_t make_result(bit tx, logic [31:0] addr, logic [15:0] sport,
                                       logic [15:0] dport, logic [31:0] seq,
                                       logic [31:0] ack, logic [5:0] flags,
                                       logic [2:0] slot, logic [1:0] ev,
                                       logic [1:0] st, bit fin);
    res_t r;
    r.tx_valid     = tx;
    r.tx_dest_addr = tx ? addr : '0;
    r.tx_src_port  = tx ? sport : '0;
    r.tx_dest_port = tx ? dport : '0;
    r.tx_seq       = tx ? seq : '0;
    r.tx_ack       = tx ? ack : '0;
    r.tx_flags     = tx ? flags : '0;
    r.slot_out     = slot;
    r.event_res    = ev;
    r.status       = st;
    r.last         = fin;
    return r;
  endfunction

  function automatic int grab_slot();
    int i;
    if (tbl_used >= SLOTS) return -1;
    i = tbl_used;
    tbl_used++;
    tbl_active[i] = 1'b1;
    tbl_state[i]  = ST_CLOSED;
    tbl_laddr[i]  = '0;
    tbl_lport[i]  = '0;
    tbl_raddr[i]  = '0;
    tbl_rport[i]  = '0;
    tbl_snd[i]    = isn_counter;
    isn_counter++;
    tbl_ack[i]    = '0;
    return i;
  endfunction

  task automatic predict_segment(input item_t it);
    int c;
    logic [2:0] cs;
    bit psh, fin;
    c = -1;
    for (int i = 0; i < SLOTS && c < 0; i++)
      if (tbl_active[i] && tbl_laddr[i] == it.local_addr && tbl_lport[i] == it.local_port_in
          && tbl_raddr[i] == it.remote_addr && tbl_rport[i] == it.remote_port_in)
        c = i;
    if (c < 0 && (it.flags_in & FL_SYN) != 0 && (it.flags_in & FL_ACK) == 0)
      for (int i = 0; i < SLOTS && c < 0; i++)
        if (tbl_active[i] && tbl_laddr[i] == it.local_addr &&
            tbl_lport[i] == it.local_port_in && tbl_state[i] == ST_LISTEN) begin
          c = i;
          tbl_raddr[i] = it.remote_addr;
          tbl_rport[i] = it.remote_port_in;
        end
    if (c < 0) begin
      expected_results.push_back(make_result(1, it.remote_addr, it.local_port_in,
        it.remote_port_in, '0, it.seq_in + 1, FL_RST | FL_ACK, '0, EV_NONE, STAT_OK, 1));
      return;
    end
    cs = tbl_state[c];
    if (cs == ST_LISTEN && (it.flags_in & FL_SYN) != 0) begin
      tbl_ack[c] = it.seq_in + 1;
      tbl_snd[c] = isn_counter;
      isn_counter++;
      tbl_state[c] = ST_SYN_RCVD;
      expected_results.push_back(make_result(1, it.remote_addr, it.local_port_in,
        it.remote_port_in, tbl_snd[c], tbl_ack[c], FL_SYN | FL_ACK, c[2:0], EV_NONE,
        STAT_OK, 1));
    end else if (cs == ST_SYN_SENT && (it.flags_in & (FL_SYN | FL_ACK)) == (FL_SYN | FL_ACK))
    begin
      tbl_ack[c] = it.seq_in + 1;
      tbl_state[c] = ST_ESTAB;
      expected_results.push_back(make_result(1, it.remote_addr, it.local_port_in,
        it.remote_port_in, tbl_snd[c] + 1, tbl_ack[c], FL_ACK, c[2:0], EV_CONNECTED,
        STAT_OK, 1));
    end else if (cs == ST_SYN_RCVD && (it.flags_in & FL_ACK) != 0) begin
      tbl_state[c] = ST_ESTAB;
      expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, c[2:0],
        EV_CONNECTED, STAT_OK, 1));
    end else if (cs == ST_ESTAB && (it.flags_in & (FL_PSH | FL_FIN)) != 0) begin
      psh = (it.flags_in & FL_PSH) != 0;
      fin = (it.flags_in & FL_FIN) != 0;
      if (psh) begin
        tbl_ack[c] = it.seq_in + 32'(it.length);
        expected_results.push_back(make_result(1, it.remote_addr, it.local_port_in,
          it.remote_port_in, tbl_snd[c], tbl_ack[c], FL_ACK, c[2:0],
          it.length != 0 ? EV_DATA : EV_NONE, STAT_OK, !fin));
      end
      if (fin) begin
        tbl_ack[c] = it.seq_in + 1;
        tbl_state[c] = ST_CLOSE_WAIT;
        expected_results.push_back(make_result(1, it.remote_addr, it.local_port_in,
          it.remote_port_in, tbl_snd[c], tbl_ack[c], FL_ACK, c[2:0], EV_CLOSED,
          STAT_OK, 1));
      end
    end else
      expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, c[2:0], EV_NONE,
        STAT_OK, 1));
  endtask

  task automatic predict_item(input item_t it);
    int c;
    logic [2:0] s;
    s = it.slot;
    case (it.mode)
      MODE_RECV: predict_segment(it);
      MODE_LISTEN: begin
        c = grab_slot();
        if (c < 0)
          expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, '0, EV_NONE,
            STAT_FULL, 1));
        else begin
          tbl_laddr[c] = it.local_addr;
          tbl_lport[c] = it.local_port_in;
          tbl_state[c] = ST_LISTEN;
          expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, c[2:0],
            EV_NONE, STAT_OK, 1));
        end
      end
      MODE_CONNECT: begin
        if (it.remote_addr == 0 || it.remote_port_in == 0)
          expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, '0, EV_NONE,
            STAT_INVALID, 1));
        else begin
          c = grab_slot();
          if (c < 0)
            expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, '0,
              EV_NONE, STAT_FULL, 1));
          else begin
            tbl_laddr[c] = it.local_addr;
            tbl_lport[c] = 16'(32'd32768 + (isn_counter % 32'd32768));
            tbl_raddr[c] = it.remote_addr;
            tbl_rport[c] = it.remote_port_in;
            tbl_state[c] = ST_SYN_SENT;
            expected_results.push_back(make_result(1, tbl_raddr[c], tbl_lport[c],
              tbl_rport[c], tbl_snd[c], '0, FL_SYN, c[2:0], EV_NONE, STAT_OK, 1));
          end
        end
      end
      MODE_SEND: begin
        if (tbl_state[s] != ST_ESTAB || it.length == 0 || it.length > PAYLOAD_MAX)
          expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, s, EV_NONE,
            STAT_INVALID, 1));
        else begin
          expected_results.push_back(make_result(1, tbl_raddr[s], tbl_lport[s],
            tbl_rport[s], tbl_snd[s], tbl_ack[s], FL_PSH | FL_ACK, s, EV_NONE,
            STAT_OK, 1));
          tbl_snd[s] = tbl_snd[s] + 32'(it.length);
        end
      end
      MODE_CLOSE: begin
        if (tbl_state[s] == ST_CLOSED)
          expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, s, EV_NONE,
            STAT_INVALID, 1));
        else begin
          expected_results.push_back(make_result(tbl_state[s] == ST_ESTAB, tbl_raddr[s],
            tbl_lport[s], tbl_rport[s], tbl_snd[s], tbl_ack[s], FL_FIN | FL_ACK, s,
            EV_NONE, STAT_OK, 1));
          tbl_active[s] = 1'b0;
          tbl_state[s] = ST_CLOSED;
        end
      end
      default:
        expected_results.push_back(make_result(0, '0, '0, '0, '0, '0, '0, '0, EV_NONE,
          STAT_INVALID, 1));
    endcase
  endtask

  // Driver: bursts of transactions separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0)
            burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0)
            gap_left <= gap_left - 1;
        end
      end
    end
  end

  // Monitor and stall pattern of the result side.
  int stall_phase = 0;
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", exp_r, out_data);
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 30) out_stall <= 1'b0;
      else if (stall_phase < 60) out_stall <= ($urandom_range(0, 2) == 0);
      else out_stall <= ($urandom_range(0, 5) == 0);
    end
  end

  function automatic item_t rand_item();
    item_t it;
    it.mode = 3'($urandom_range(0, 7));
    it.slot = 3'($urandom);
    it.local_addr = $urandom;
    it.local_port_in = 16'($urandom);
    it.remote_addr = $urandom;
    it.remote_port_in = 16'($urandom);
    it.seq_in = $urandom;
    it.flags_in = 6'($urandom);
    it.length = 11'($urandom);
    return it;
  endfunction

  function automatic item_t mk_item(logic [2:0] m, logic [2:0] s, logic [31:0] la,
                                    logic [15:0] lp, logic [31:0] ra, logic [15:0] rp,
                                    logic [31:0] sq, logic [5:0] fl, logic [10:0] ln);
    item_t it;
    it.mode = m; it.slot = s; it.local_addr = la; it.local_port_in = lp;
    it.remote_addr = ra; it.remote_port_in = rp; it.seq_in = sq; it.flags_in = fl;
    it.length = ln;
    return it;
  endfunction

  // Generates one table's lifetime: listeners and connects, handshakes, data, closes.
  task automatic add_session_set();
    logic [31:0] la[SLOTS], ra[SLOTS], sq;
    logic [15:0] lp[SLOTS], rp[SLOTS];
    logic [31:0] isn;
    bit passive[SLOTS];
    int n;
    isn = 32'd1000;
    for (int i = 0; i < SLOTS; i++) begin
      la[i] = $urandom; ra[i] = $urandom | 1; rp[i] = 16'($urandom | 1);
      passive[i] = 1'($urandom_range(0, 1));
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (passive[i]) begin
        lp[i] = 16'($urandom);
        pending_items.push_back(mk_item(MODE_LISTEN, 0, la[i], lp[i], 0, 0, 0, 0, 0));
        isn++;
      end else begin
        lp[i] = 16'(32'd32768 + ((isn + 1) % 32'd32768));
        pending_items.push_back(mk_item(MODE_CONNECT, 0, la[i], 0, ra[i], rp[i], 0, 0, 0));
        isn++;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      sq = $urandom;
      if (passive[i]) begin
        pending_items.push_back(mk_item(MODE_RECV, 0, la[i], lp[i], ra[i], rp[i], sq,
          FL_SYN, 0));
        pending_items.push_back(mk_item(MODE_RECV, 0, la[i], lp[i], ra[i], rp[i], sq + 1,
          FL_ACK, 0));
      end else
        pending_items.push_back(mk_item(MODE_RECV, 0, la[i], lp[i], ra[i], rp[i], sq,
          FL_SYN | FL_ACK, 0));
    end
    n = $urandom_range(20, 50);
    for (int k = 0; k < n; k++) begin
      int j;
      item_t it;
      j = $urandom_range(0, SLOTS - 1);
      case ($urandom_range(0, 9))
        0, 1, 2: pending_items.push_back(mk_item(MODE_SEND, j[2:0], 0, 0, 0, 0, 0, 0,
                   11'($urandom_range(1, PAYLOAD_MAX))));
        3, 4, 5: pending_items.push_back(mk_item(MODE_RECV, 0, la[j], lp[j], ra[j], rp[j],
                   $urandom, FL_PSH | FL_ACK | ($urandom_range(0, 7) == 0 ? FL_FIN : 6'd0),
                   11'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                 : $urandom_range(0, 1460))));
        6: pending_items.push_back(mk_item(MODE_RECV, 0, la[j], lp[j], ra[j], rp[j],
             $urandom, 6'($urandom), 11'($urandom)));
        7: pending_items.push_back(mk_item(MODE_CLOSE, j[2:0], 0, 0, 0, 0, 0, 0, 0));
        default: begin
          it = rand_item();
          pending_items.push_back(it);
        end
      endcase
    end
    for (int i = 0; i < SLOTS; i++)
      pending_items.push_back(mk_item(MODE_CLOSE, i[2:0], 0, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_active[i] = 0; tbl_state[i] = ST_CLOSED; tbl_laddr[i] = '0; tbl_lport[i] = '0;
      tbl_raddr[i] = '0; tbl_rport[i] = '0; tbl_snd[i] = '0; tbl_ack[i] = '0;
    end
    tbl_used = 0;
    isn_counter = INITIAL_SEQ;
    // Directed part: no match, bad operations, extremes, then a full session.
    pending_items.push_back(mk_item(MODE_RECV, 0, '1, '1, '1, '1, '1, '1, '1));
    pending_items.push_back(mk_item(MODE_RECV, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(3'd5, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(3'd7, '1, '1, '1, '1, '1, '1, '1, '1));
    pending_items.push_back(mk_item(MODE_SEND, 3'd7, 0, 0, 0, 0, 0, 0, 11'd100));
    pending_items.push_back(mk_item(MODE_CLOSE, 3'd0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(MODE_CONNECT, 0, 1, 0, 0, 5, 0, 0, 0));
    pending_items.push_back(mk_item(MODE_CONNECT, 0, 1, 0, 7, 0, 0, 0, 0));
    pending_items.push_back(mk_item(MODE_LISTEN, 0, 32'h0a000001, 16'd80, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(MODE_RECV, 0, 32'h0a000001, 16'd80, 32'h0b000002,
      16'd5000, 32'hffffffff, FL_SYN, 0));
    pending_items.push_back(mk_item(MODE_SEND, 0, 0, 0, 0, 0, 0, 0, 11'd10));
    pending_items.push_back(mk_item(MODE_RECV, 0, 32'h0a000001, 16'd80, 32'h0b000002,
      16'd5000, 0, FL_ACK, 0));
    pending_items.push_back(mk_item(MODE_SEND, 0, 0, 0, 0, 0, 0, 0, 11'd0));
    pending_items.push_back(mk_item(MODE_SEND, 0, 0, 0, 0, 0, 0, 0, 11'd1461));
    pending_items.push_back(mk_item(MODE_SEND, 0, 0, 0, 0, 0, 0, 0, 11'd1460));
    pending_items.push_back(mk_item(MODE_RECV, 0, 32'h0a000001, 16'd80, 32'h0b000002,
      16'd5000, 32'd77, FL_PSH | FL_ACK, 11'd0));
    pending_items.push_back(mk_item(MODE_RECV, 0, 32'h0a000001, 16'd80, 32'h0b000002,
      16'd5000, 32'd77, FL_PSH | FL_FIN | FL_ACK, 11'd2047));
    pending_items.push_back(mk_item(MODE_RECV, 0, 32'h0a000001, 16'd80, 32'h0b000002,
      16'd5000, 32'd90, FL_ACK, 0));
    pending_items.push_back(mk_item(MODE_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(MODE_CONNECT, 0, 32'h0c, 0, '1, '1, 0, 0, 0));
    pending_items.push_back(mk_item(MODE_CLOSE, 1, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 6; i++)
      pending_items.push_back(mk_item(MODE_LISTEN, 0, i, 16'(i), 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(MODE_CONNECT, 0, 1, 0, 1, 1, 0, 0, 0));
    // The table never frees slots, so from here on it stays full: the random items
    // and session sets below mostly exercise the full, invalid and no-match paths.
    repeat (725) pending_items.push_back(rand_item());
    repeat (7 * 1) add_session_set();
    repeat (12) begin
      add_session_set();
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    wait (!in_valid);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
